// ===== rtl/etrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package etrm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;

  // Internal fixed point: 30 fraction bits, one = 2^30.
  localparam int FRAC = 30;
  localparam int ZW = FRAC + 3;
  localparam int ZSHIFT = FRAC - (ANGLE_BITS - 3);
  localparam int SUM_W = FRAC + 4;
  localparam int TERMS = 8;

  localparam int TERM_STAGES = 4;
  localparam int SC_STAGES = 3 + TERMS * TERM_STAGES + 1;
  localparam int PROD_STAGES = 7;
  localparam int LATENCY = SC_STAGES + PROD_STAGES;

  localparam logic signed [ZW+1:0] PI_Q = (ZW+2)'(64'sd3373259426);
  localparam logic signed [ZW+1:0] HALF_PI_Q = (ZW+2)'(64'sd1686629713);
  localparam logic signed [ZW+1:0] NEG_HALF_PI_Q = (ZW+2)'(-64'sd1686629713);

  typedef logic [FRAC:0] mag_t;
  typedef logic [31:0] term_t;
  typedef logic [8:0] div_t;
  typedef logic [32:0] recip_t;

  typedef struct packed {
    mag_t sin_mag;
    logic sin_neg;
    mag_t cos_mag;
    logic cos_neg;
  } trig_t;

  // Divisors of the Taylor terms and floor(2^33 / divisor).
  function automatic div_t sin_div(int k);
    unique case (k)
      0: return 9'd6;
      1: return 9'd20;
      2: return 9'd42;
      3: return 9'd72;
      4: return 9'd110;
      5: return 9'd156;
      6: return 9'd210;
      default: return 9'd272;
    endcase
  endfunction

  function automatic recip_t sin_recip(int k);
    unique case (k)
      0: return 33'd1431655765;
      1: return 33'd429496729;
      2: return 33'd204522252;
      3: return 33'd119304647;
      4: return 33'd78090314;
      5: return 33'd55063683;
      6: return 33'd40904450;
      default: return 33'd31580641;
    endcase
  endfunction

  function automatic div_t cos_div(int k);
    unique case (k)
      0: return 9'd2;
      1: return 9'd12;
      2: return 9'd30;
      3: return 9'd56;
      4: return 9'd90;
      5: return 9'd132;
      6: return 9'd182;
      default: return 9'd240;
    endcase
  endfunction

  function automatic recip_t cos_recip(int k);
    unique case (k)
      0: return 33'd4294967296;
      1: return 33'd715827882;
      2: return 33'd286331153;
      3: return 33'd153391689;
      4: return 33'd95443717;
      5: return 33'd65075262;
      6: return 33'd47197442;
      default: return 33'd35791394;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/etrm_term.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etrm_term
  import etrm_pkg::*;
(
  input  logic   clk,
  input  term_t  t_in,
  input  term_t  w,
  input  div_t   d,
  input  recip_t m,
  output term_t  t_out
);

  logic [63:0] prod;
  logic [63:0] prod_rnd;
  logic [32:0] y;
  logic [32:0] y_d;
  logic [65:0] scaled;
  logic [32:0] q_est;
  logic [32:0] rem;

  assign prod_rnd = prod + (64'd1 << (FRAC - 1));

  // The reciprocal estimate is low by at most one; the remainder fixes it.
  assign q_est = scaled[65:33];
  assign rem = y_d - 33'(q_est * 33'(d));

  always_ff @(posedge clk) begin
    prod <= 64'(t_in) * 64'(w);
    y <= prod_rnd[FRAC+32:FRAC] + 33'(d >> 1);
    scaled <= 66'(y) * 66'(m);
    y_d <= y;
    t_out <= 32'(q_est + 33'(rem >= 33'(d)));
  end

endmodule

`default_nettype wire

// ===== rtl/etrm_sincos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etrm_sincos
  import etrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  out_valid,
  output trig_t                 trig
);

  typedef struct packed {
    logic                    valid;
    logic                    zneg;
    logic                    fold;
    term_t                   w;
    logic signed [SUM_W-1:0] ssum;
    logic signed [SUM_W-1:0] csum;
  } sb_t;

  localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(64'd1 << FRAC);

  function automatic sb_t add_term(sb_t s, term_t ts_k, term_t tc_k, logic sub);
    sb_t r;
    r = s;
    if (sub) begin
      r.ssum = s.ssum - SUM_W'(ts_k);
      r.csum = s.csum - SUM_W'(tc_k);
    end else begin
      r.ssum = s.ssum + SUM_W'(ts_k);
      r.csum = s.csum + SUM_W'(tc_k);
    end
    return r;
  endfunction

  function automatic mag_t clamp_mag(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] a;
    a = v[SUM_W-1] ? -v : v;
    if (a > ONE_Q) begin
      a = ONE_Q;
    end
    return a[FRAC:0];
  endfunction

  logic signed [ZW+1:0] z_ext;
  logic signed [ZW+1:0] z_fold;
  logic                 fold_c;
  mag_t                 u_c;

  logic           v1, zneg1, fold1;
  mag_t           u1;
  logic           v2, zneg2, fold2;
  mag_t           u2;
  logic [2*FRAC+1:0] sq2;
  logic [2*FRAC+1:0] sq_rnd;

  sb_t   sb_start;
  term_t ts0, tc0;
  sb_t   chain [TERMS][TERM_STAGES];
  sb_t   entry [TERMS];
  term_t ts_in [TERMS];
  term_t tc_in [TERMS];
  term_t ts_out [TERMS];
  term_t tc_out [TERMS];
  sb_t   last;

  assign z_ext = (ZW+2)'(signed'(angle)) <<< ZSHIFT;

  // Fold into [-pi/2, pi/2]; a fold negates both sine and cosine.
  always_comb begin
    z_fold = z_ext;
    fold_c = 1'b0;
    if (z_ext > HALF_PI_Q) begin
      z_fold = z_ext - PI_Q;
      fold_c = 1'b1;
    end else if (z_ext < NEG_HALF_PI_Q) begin
      z_fold = z_ext + PI_Q;
      fold_c = 1'b1;
    end
  end

  assign u_c = z_fold[ZW+1] ? mag_t'(-z_fold) : mag_t'(z_fold);
  assign sq_rnd = sq2 + ((2*FRAC+2)'(1) << (FRAC - 1));

  always_ff @(posedge clk) begin
    u1 <= u_c;
    zneg1 <= z_fold[ZW+1];
    fold1 <= fold_c;
    u2 <= u1;
    sq2 <= (2*FRAC+2)'(u1) * (2*FRAC+2)'(u1);
    zneg2 <= zneg1;
    fold2 <= fold1;
    sb_start.zneg <= zneg2;
    sb_start.fold <= fold2;
    sb_start.w <= sq_rnd[FRAC+31:FRAC];
    sb_start.ssum <= SUM_W'(u2);
    sb_start.csum <= ONE_Q;
    ts0 <= 32'(u2);
    tc0 <= 32'd1 << FRAC;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      sb_start.valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      sb_start.valid <= v2;
    end
  end

  // Each term's sums pick up the previous term as they enter its stages.
  always_comb begin
    for (int k = 0; k < TERMS; k++) begin
      if (k == 0) begin
        entry[k] = sb_start;
        ts_in[k] = ts0;
        tc_in[k] = tc0;
      end else begin
        entry[k] = add_term(chain[k-1][TERM_STAGES-1], ts_out[k-1], tc_out[k-1],
                            (k % 2) == 1);
        ts_in[k] = ts_out[k-1];
        tc_in[k] = tc_out[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TERMS; k++) begin
      if (rst) begin
        for (int j = 0; j < TERM_STAGES; j++) begin
          chain[k][j].valid <= 1'b0;
        end
      end else begin
        chain[k][0] <= entry[k];
        for (int j = 1; j < TERM_STAGES; j++) begin
          chain[k][j] <= chain[k][j-1];
        end
      end
    end
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    etrm_term u_sin (
      .clk   (clk),
      .t_in  (ts_in[k]),
      .w     (entry[k].w),
      .d     (sin_div(k)),
      .m     (sin_recip(k)),
      .t_out (ts_out[k])
    );
    etrm_term u_cos (
      .clk   (clk),
      .t_in  (tc_in[k]),
      .w     (entry[k].w),
      .d     (cos_div(k)),
      .m     (cos_recip(k)),
      .t_out (tc_out[k])
    );
  end

  assign last = add_term(chain[TERMS-1][TERM_STAGES-1], ts_out[TERMS-1],
                         tc_out[TERMS-1], (TERMS % 2) == 1);

  always_ff @(posedge clk) begin
    trig.sin_mag <= clamp_mag(last.ssum);
    trig.sin_neg <= last.ssum[SUM_W-1] ^ last.zneg ^ last.fold;
    trig.cos_mag <= clamp_mag(last.csum);
    trig.cos_neg <= last.csum[SUM_W-1] ^ last.fold;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= last.valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/euler_to_rotation_matrix.sv =====
// Pipeline: a transaction accepted at a clock edge shows its matrix with done after passing
// 36 sine/cosine stages (fold, square, load, eight Taylor terms of four stages each, clamp)
// and 7 product stages.
// Throughput: one transaction per cycle; busy is always low and nothing can stall the pipeline.
// Reset: synchronous rst clears all valid bits; the entry registers keep their last values.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_rotation_matrix
  import etrm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ANGLE_BITS-1:0] heading_angle,
  input  logic signed [ANGLE_BITS-1:0] attitude_angle,
  input  logic signed [ANGLE_BITS-1:0] bank_angle,
  output logic                         done,
  output logic signed [ENTRY_BITS-1:0] row0_col0,
  output logic signed [ENTRY_BITS-1:0] row0_col1,
  output logic signed [ENTRY_BITS-1:0] row0_col2,
  output logic signed [ENTRY_BITS-1:0] row1_col0,
  output logic signed [ENTRY_BITS-1:0] row1_col1,
  output logic signed [ENTRY_BITS-1:0] row1_col2,
  output logic signed [ENTRY_BITS-1:0] row2_col0,
  output logic signed [ENTRY_BITS-1:0] row2_col1,
  output logic signed [ENTRY_BITS-1:0] row2_col2
);

  localparam int NUM_ENTRIES = 9;
  localparam int SW = FRAC + 3;
  localparam int SH = FRAC - (ENTRY_BITS - 2);
  localparam longint RND = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
  localparam longint LIM = 64'd1 << (ENTRY_BITS - 2);

  typedef struct packed {
    logic [2*FRAC+1:0] mag;
    logic              neg;
  } wide_t;

  typedef struct packed {
    mag_t mag;
    logic neg;
  } fix_t;

  typedef struct packed {
    fix_t c1c2;
    fix_t s1s3;
    fix_t s1c3;
    fix_t c2c3;
    fix_t c2s3;
    fix_t s1c2;
    fix_t c1s3;
    fix_t c1c3;
    fix_t s2;
  } first_t;

  function automatic wide_t smul(fix_t a, fix_t b);
    wide_t r;
    r.mag = (2*FRAC+2)'(a.mag) * (2*FRAC+2)'(b.mag);
    r.neg = a.neg ^ b.neg;
    return r;
  endfunction

  function automatic fix_t rnd(wide_t p);
    fix_t              r;
    logic [2*FRAC+1:0] t;
    t = p.mag + ((2*FRAC+2)'(1) << (FRAC - 1));
    r.mag = t[2*FRAC:FRAC];
    r.neg = p.neg;
    return r;
  endfunction

  function automatic logic signed [SW-1:0] sval(fix_t a);
    logic signed [SW-1:0] m;
    m = SW'(a.mag);
    return a.neg ? -m : m;
  endfunction

  logic  acc;
  logic  v_h, v_a, v_b, sc_valid;
  trig_t t1, t2, t3;
  fix_t  s1, c1, s2, c2, s3, c3;

  logic [PROD_STAGES-1:0] vpipe;

  wide_t  w_c1s2, w_s1s2, w_c1c2, w_s1s3, w_s1c3, w_c2c3, w_c2s3, w_s1c2, w_c1s3, w_c1c3;
  fix_t   s2_p1, s3_p1, c3_p1;
  fix_t   f_c1s2, f_s1s2, s3_p2, c3_p2;
  first_t first_p2, first_p3, first_p4;
  wide_t  x_c1s2c3, x_c1s2s3, x_s1s2c3, x_s1s2s3;
  fix_t   g_c1s2c3, g_c1s2s3, g_s1s2c3, g_s1s2s3;

  logic signed [SW-1:0] e5q [NUM_ENTRIES];
  logic [SW-2:0]        m6q [NUM_ENTRIES];
  logic                 n6q [NUM_ENTRIES];
  logic [SW-1:0]        r7 [NUM_ENTRIES];
  logic signed [ENTRY_BITS-1:0] ent [NUM_ENTRIES];

  assign busy = 1'b0;
  assign acc = start & ~busy;

  etrm_sincos u_sc_heading (
    .clk(clk), .rst(rst), .in_valid(acc), .angle(heading_angle),
    .out_valid(v_h), .trig(t1)
  );
  etrm_sincos u_sc_attitude (
    .clk(clk), .rst(rst), .in_valid(acc), .angle(attitude_angle),
    .out_valid(v_a), .trig(t2)
  );
  etrm_sincos u_sc_bank (
    .clk(clk), .rst(rst), .in_valid(acc), .angle(bank_angle),
    .out_valid(v_b), .trig(t3)
  );

  assign sc_valid = v_h & v_a & v_b;
  assign s1 = '{mag: t1.sin_mag, neg: t1.sin_neg};
  assign c1 = '{mag: t1.cos_mag, neg: t1.cos_neg};
  assign s2 = '{mag: t2.sin_mag, neg: t2.sin_neg};
  assign c2 = '{mag: t2.cos_mag, neg: t2.cos_neg};
  assign s3 = '{mag: t3.sin_mag, neg: t3.sin_neg};
  assign c3 = '{mag: t3.cos_mag, neg: t3.cos_neg};

  always_ff @(posedge clk) begin
    // First-level products.
    w_c1s2 <= smul(c1, s2);
    w_s1s2 <= smul(s1, s2);
    w_c1c2 <= smul(c1, c2);
    w_s1s3 <= smul(s1, s3);
    w_s1c3 <= smul(s1, c3);
    w_c2c3 <= smul(c2, c3);
    w_c2s3 <= smul(c2, s3);
    w_s1c2 <= smul(s1, c2);
    w_c1s3 <= smul(c1, s3);
    w_c1c3 <= smul(c1, c3);
    s2_p1 <= s2;
    s3_p1 <= s3;
    c3_p1 <= c3;

    f_c1s2 <= rnd(w_c1s2);
    f_s1s2 <= rnd(w_s1s2);
    first_p2.c1c2 <= rnd(w_c1c2);
    first_p2.s1s3 <= rnd(w_s1s3);
    first_p2.s1c3 <= rnd(w_s1c3);
    first_p2.c2c3 <= rnd(w_c2c3);
    first_p2.c2s3 <= rnd(w_c2s3);
    first_p2.s1c2 <= rnd(w_s1c2);
    first_p2.c1s3 <= rnd(w_c1s3);
    first_p2.c1c3 <= rnd(w_c1c3);
    first_p2.s2 <= s2_p1;
    s3_p2 <= s3_p1;
    c3_p2 <= c3_p1;

    // Triple products, always ((first * second) * third).
    x_c1s2c3 <= smul(f_c1s2, c3_p2);
    x_c1s2s3 <= smul(f_c1s2, s3_p2);
    x_s1s2c3 <= smul(f_s1s2, c3_p2);
    x_s1s2s3 <= smul(f_s1s2, s3_p2);
    first_p3 <= first_p2;

    g_c1s2c3 <= rnd(x_c1s2c3);
    g_c1s2s3 <= rnd(x_c1s2s3);
    g_s1s2c3 <= rnd(x_s1s2c3);
    g_s1s2s3 <= rnd(x_s1s2s3);
    first_p4 <= first_p3;

    e5q[0] <= sval(first_p4.c1c2);
    e5q[1] <= sval(first_p4.s1s3) - sval(g_c1s2c3);
    e5q[2] <= sval(g_c1s2s3) + sval(first_p4.s1c3);
    e5q[3] <= sval(first_p4.s2);
    e5q[4] <= sval(first_p4.c2c3);
    e5q[5] <= -sval(first_p4.c2s3);
    e5q[6] <= -sval(first_p4.s1c2);
    e5q[7] <= sval(g_s1s2c3) + sval(first_p4.c1s3);
    e5q[8] <= sval(first_p4.c1c3) - sval(g_s1s2s3);

    for (int i = 0; i < NUM_ENTRIES; i++) begin
      m6q[i] <= e5q[i][SW-1] ? (SW-1)'(-e5q[i]) : e5q[i][SW-2:0];
      n6q[i] <= e5q[i][SW-1];
      ent[i] <= ENTRY_BITS'(n6q[i] ? -r7[i] : r7[i]);
    end

    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PROD_STAGES-2:0], sc_valid};
    end
  end

  // Round the magnitude to the entry's fraction bits and saturate at one.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      r7[i] = (SW'(m6q[i]) + SW'(RND)) >> SH;
      if (r7[i] > SW'(LIM)) begin
        r7[i] = SW'(LIM);
      end
    end
  end

  assign done = vpipe[PROD_STAGES-1];
  assign row0_col0 = ent[0];
  assign row0_col1 = ent[1];
  assign row0_col2 = ent[2];
  assign row1_col0 = ent[3];
  assign row1_col1 = ent[4];
  assign row1_col2 = ent[5];
  assign row2_col0 = ent[6];
  assign row2_col1 = ent[7];
  assign row2_col2 = ent[8];

endmodule

`default_nettype wire

// ===== rtl/etrm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etrm_checker
  import etrm_pkg::*;
(
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic signed [ANGLE_BITS-1:0] heading_angle,
  input wire logic signed [ANGLE_BITS-1:0] attitude_angle,
  input wire logic signed [ANGLE_BITS-1:0] bank_angle,
  input wire logic                         done,
  input wire logic signed [ENTRY_BITS-1:0] row0_col0,
  input wire logic signed [ENTRY_BITS-1:0] row0_col1,
  input wire logic signed [ENTRY_BITS-1:0] row0_col2,
  input wire logic signed [ENTRY_BITS-1:0] row1_col0,
  input wire logic signed [ENTRY_BITS-1:0] row1_col1,
  input wire logic signed [ENTRY_BITS-1:0] row1_col2,
  input wire logic signed [ENTRY_BITS-1:0] row2_col0,
  input wire logic signed [ENTRY_BITS-1:0] row2_col1,
  input wire logic signed [ENTRY_BITS-1:0] row2_col2
);

  localparam logic signed [ENTRY_BITS-1:0] ENT_MAX = ENTRY_BITS'(64'd1 << (ENTRY_BITS - 2));
  localparam logic signed [ENTRY_BITS-1:0] ENT_MIN = -ENT_MAX;

  // Reset flushes every transaction in flight.
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done high right after reset");

  // Every accepted transaction comes out after the fixed latency.
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction did not produce a result");

  // No result appears without a transaction accepted the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  // Saturated sums stay within plus or minus one.
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    done |-> (row0_col1 <= ENT_MAX) && (row0_col1 >= ENT_MIN) &&
             (row2_col2 <= ENT_MAX) && (row2_col2 >= ENT_MIN))
    else $error("matrix entry beyond plus or minus one");

endmodule

bind euler_to_rotation_matrix etrm_checker u_etrm_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import etrm_pkg::*;

  localparam int FRACB = 30;
  localparam longint ONEQ = 64'sd1 << FRACB;
  localparam longint PIQ = 64'sd3373259426;
  localparam longint HPIQ = 64'sd1686629713;
  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 1880;

  typedef logic signed [ENTRY_BITS-1:0] entry_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef struct {
    entry_t e [9];
  } matrix_t;
  typedef struct {
    angle_t h, a, b;
    logic   known;
    matrix_t m;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  angle_t heading_angle = '0, attitude_angle = '0, bank_angle = '0;
  entry_t out_e [9];

  matrix_t expected_q [$];
  int errors = 0;
  int idle_cycles = 0;

  euler_to_rotation_matrix i_dut (
    .clk, .rst, .start, .busy,
    .heading_angle, .attitude_angle, .bank_angle,
    .done,
    .row0_col0(out_e[0]), .row0_col1(out_e[1]), .row0_col2(out_e[2]),
    .row1_col0(out_e[3]), .row1_col1(out_e[4]), .row1_col2(out_e[5]),
    .row2_col0(out_e[6]), .row2_col1(out_e[7]), .row2_col2(out_e[8])
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint qmul(longint x, longint y);
    longint ax, ay, p;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    p = (ax * ay + (64'sd1 <<< (FRACB - 1))) >>> FRACB;
    return ((x < 0) != (y < 0)) ? -p : p;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void trig(input angle_t ang, output longint sn, output longint cs);
    longint z, u, w, ts, tc, ds, dc, ss, cc;
    bit fold;
    z = longint'(ang) <<< (FRACB - (ANGLE_BITS - 3));
    fold = 1'b0;
    if (z > HPIQ) begin
      z -= PIQ;
      fold = 1'b1;
    end else if (z < -HPIQ) begin
      z += PIQ;
      fold = 1'b1;
    end
    u = (z < 0) ? -z : z;
    w = (u * u + (64'sd1 <<< (FRACB - 1))) >>> FRACB;
    ts = u;
    tc = ONEQ;
    ss = ts;
    cc = tc;
    for (int k = 1; k <= 8; k++) begin
      ds = (2 * k) * (2 * k + 1);
      dc = (2 * k - 1) * (2 * k);
      ts = (ts * w + (64'sd1 <<< (FRACB - 1))) >>> FRACB;
      ts = (ts + ds / 2) / ds;
      tc = (tc * w + (64'sd1 <<< (FRACB - 1))) >>> FRACB;
      tc = (tc + dc / 2) / dc;
      if (k % 2) begin
        ss -= ts;
        cc -= tc;
      end else begin
        ss += ts;
        cc += tc;
      end
    end
    ss = clamp(ss, ONEQ);
    cc = clamp(cc, ONEQ);
    if (z < 0) ss = -ss;
    if (fold) begin
      ss = -ss;
      cc = -cc;
    end
    sn = ss;
    cs = cc;
  endfunction

  function automatic entry_t to_entry(longint v);
    longint m, r;
    int sh;
    sh = FRACB - (ENTRY_BITS - 2);
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    r = (v < 0) ? -m : m;
    return entry_t'(clamp(r, 64'sd1 <<< (ENTRY_BITS - 2)));
  endfunction

  function automatic matrix_t rotation(angle_t h, angle_t a, angle_t b);
    longint s1, c1, s2, c2, s3, c3, c1s2, s1s2;
    matrix_t m;
    trig(h, s1, c1);
    trig(a, s2, c2);
    trig(b, s3, c3);
    c1s2 = qmul(c1, s2);
    s1s2 = qmul(s1, s2);
    m.e[0] = to_entry(qmul(c1, c2));
    m.e[1] = to_entry(-qmul(c1s2, c3) + qmul(s1, s3));
    m.e[2] = to_entry(qmul(c1s2, s3) + qmul(s1, c3));
    m.e[3] = to_entry(s2);
    m.e[4] = to_entry(qmul(c2, c3));
    m.e[5] = to_entry(-qmul(c2, s3));
    m.e[6] = to_entry(-qmul(s1, c2));
    m.e[7] = to_entry(qmul(s1s2, c3) + qmul(c1, s3));
    m.e[8] = to_entry(-qmul(s1s2, s3) + qmul(c1, c3));
    return m;
  endfunction

  function automatic vec_t row(int h, int a, int b);
    vec_t v;
    v.h = angle_t'(h);
    v.a = angle_t'(a);
    v.b = angle_t'(b);
    v.known = 1'b0;
    return v;
  endfunction

  // Drives one transaction; start stays high across back-to-back items.
  task automatic send(input angle_t h, input angle_t a, input angle_t b, input matrix_t m);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    heading_angle <= h;
    attitude_angle <= a;
    bank_angle <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(m);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with no pending transaction");
          errors++;
        end else begin
          matrix_t ex;
          ex = expected_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (out_e[i] !== ex.e[i]) begin
              $error("row%0d_col%0d expected %0d actual %0d", i / 3, i % 3, ex.e[i], out_e[i]);
              errors++;
            end
        end
      end
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < WATCHDOG) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    vec_t dir [$];
    vec_t v;
    matrix_t ident;
    for (int i = 0; i < 9; i++) ident.e[i] = (i % 4 == 0) ? entry_t'(16384) : '0;
    v = row(0, 0, 0);
    v.known = 1'b1;
    v.m = ident;
    dir.push_back(v);
    dir.push_back(row(32767, 32767, 32767));
    dir.push_back(row(-32768, -32768, -32768));
    dir.push_back(row(-32768, 0, 32767));
    dir.push_back(row(12868, 0, 0));
    dir.push_back(row(0, 12868, 0));
    dir.push_back(row(0, 0, 12868));
    dir.push_back(row(12867, 12869, -12868));
    dir.push_back(row(25736, -25736, 25736));
    dir.push_back(row(1, -1, 1));
    dir.push_back(row(6434, 6434, 6434));
    dir.push_back(row(-12868, -12869, 12869));
    dir.push_back(row(16'h5555, 16'hAAAA, 16'h5555));
    dir.push_back(row(16'hAAAA, 16'h5555, 16'hAAAA));
    dir.push_back(row(19302, 3217, -19302));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (dir[i]) begin
      v = dir[i];
      if (!v.known) v.m = rotation(v.h, v.a, v.b);
      send(v.h, v.a, v.b, v.m);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      angle_t h, a, b;
      h = angle_t'($urandom);
      a = angle_t'($urandom);
      b = angle_t'($urandom);
      // Some items sit close to the fold points at plus and minus pi/2.
      if ($urandom_range(0, 7) == 0) a = angle_t'(($urandom_range(0, 1) ? 12868 : -12868)
                                                   + int'($urandom_range(0, 6)) - 3);
      send(h, a, b, rotation(h, a, b));
    end
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
